/* hw/rtl/wfn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfn_pkg
// Shared constants, types and helpers for the sliding-window first-negative
// search.
// ----------------------------------------------------------------------------
package wfn_pkg;

  // Window limits and field widths
  localparam int MAX_WINDOW = 256;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int CFG_W      = 9;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 16;
  localparam int ENTRY_W    = DATA_W + POS_W;

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

  // One queued negative sample with its stream position
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos;
  } entry_t;

  // One result item
  typedef struct packed {
    logic signed [DATA_W-1:0] first_negative;
    logic                     found;
  } result_t;

  // Ring pointer advance
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(MAX_WINDOW - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Window size as used: zero acts as one, oversize acts as the maximum
  function automatic logic [CNT_W-1:0] clamp_window(input logic [CFG_W-1:0] ws);
    logic [CNT_W-1:0] k;
    if (ws == '0) begin
      k = CNT_W'(1);
    end else if (32'(ws) > MAX_WINDOW) begin
      k = CNT_W'(MAX_WINDOW);
    end else begin
      k = CNT_W'(ws);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/wfn_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfn_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module wfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/wfn_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfn_queue
// Ring queue of negative samples held in RAM. The front entry lives in a
// register; the RAM read port always prefetches the entry behind it so a
// retire can promote it in the next cycle. Writes to the prefetched entry in
// the cycle before are forwarded.
// ----------------------------------------------------------------------------
module wfn_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic signed [wfn_pkg::DATA_W-1:0] sample,
  input  wire logic                          last_sample,
  input  wire logic [wfn_pkg::CFG_W-1:0]     window_size,
  output logic                               has_result,
  output wfn_pkg::result_t                   result
);

  // Sequence state
  logic [wfn_pkg::PTR_W-1:0] head, head_next;
  logic [wfn_pkg::PTR_W-1:0] tail, tail_next;
  logic [wfn_pkg::CNT_W-1:0] count, count_next;
  logic [wfn_pkg::POS_W-1:0] position;
  logic [wfn_pkg::CNT_W-1:0] seen, seen_next;
  wfn_pkg::entry_t           front, front_next;

  // Forwarding of the last write
  logic                      fwd;
  wfn_pkg::entry_t           wr_hold;

  logic [wfn_pkg::CNT_W-1:0] k;
  logic [wfn_pkg::POS_W-1:0] target;
  logic                      do_pop, do_push;
  logic [wfn_pkg::CNT_W-1:0] cnt_pop;
  wfn_pkg::entry_t           new_entry, second, rd_entry;
  logic [wfn_pkg::PTR_W-1:0] rd_addr;
  logic                      ram_we;
  logic [wfn_pkg::ENTRY_W-1:0] ram_rdata;

  // Retire / queue decisions for the item at the input
  always_comb begin
    k         = wfn_pkg::clamp_window(window_size);
    target    = position - wfn_pkg::POS_W'(k);
    do_pop    = (count != '0) && (front.pos == target);
    cnt_pop   = count - wfn_pkg::CNT_W'(do_pop);
    do_push   = sample[wfn_pkg::DATA_W-1] && (cnt_pop != wfn_pkg::CNT_W'(wfn_pkg::MAX_WINDOW));
    new_entry = '{value: sample, pos: position};
    rd_entry  = wfn_pkg::entry_t'(ram_rdata);
    second    = fwd ? wr_hold : rd_entry;

    head_next  = do_pop  ? wfn_pkg::ring_next(head) : head;
    tail_next  = do_push ? wfn_pkg::ring_next(tail) : tail;
    count_next = cnt_pop + wfn_pkg::CNT_W'(do_push);

    // New front: a push into an empty queue, or promotion after a retire
    if (do_push && (cnt_pop == '0)) begin
      front_next = new_entry;
    end else if (do_pop && (cnt_pop != '0)) begin
      front_next = second;
    end else begin
      front_next = front;
    end

    seen_next  = (seen == wfn_pkg::CNT_W'(wfn_pkg::MAX_WINDOW)) ? seen
                                                               : seen + wfn_pkg::CNT_W'(1);
    has_result = (seen_next >= k);
    result.found          = (count_next != '0);
    result.first_negative = result.found ? $signed(front_next.value) : '0;
  end

  // Prefetch address: the entry behind the front after this cycle
  always_comb begin
    if (accept) begin
      rd_addr = last_sample ? wfn_pkg::ring_next('0) : wfn_pkg::ring_next(head_next);
    end else begin
      rd_addr = wfn_pkg::ring_next(head);
    end
    ram_we = accept && do_push;
  end

  wfn_ram #(
    .WIDTH(wfn_pkg::ENTRY_W),
    .DEPTH(wfn_pkg::MAX_WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(new_entry),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      position <= '0;
      seen     <= '0;
      fwd      <= 1'b0;
    end else begin
      fwd <= ram_we && (tail == rd_addr);
      if (accept) begin
        if (last_sample) begin
          head     <= '0;
          tail     <= '0;
          count    <= '0;
          position <= '0;
          seen     <= '0;
        end else begin
          head     <= head_next;
          tail     <= tail_next;
          count    <= count_next;
          position <= position + wfn_pkg::POS_W'(1);
          seen     <= seen_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_hold <= new_entry;
    if (accept) begin
      front <= front_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wfn_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfn_out_buf
// Two-entry result buffer. The upstream side stalls only when both entries
// hold results, so an item is taken while a result waits downstream.
// ----------------------------------------------------------------------------
module wfn_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire wfn_pkg::result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output wfn_pkg::result_t      out_data
);

  logic [1:0]       fill;
  logic             pop;
  wfn_pkg::result_t e0, e1;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (fill != 2'd0);
  assign full      = (fill == 2'd2);
  assign out_data  = e0;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  // Entry data
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (fill == 2'd1) begin
        e0 <= push_data;
      end else begin
        e0 <= e1;
        e1 <= push_data;
      end
    end else if (push) begin
      if (fill == 2'd0) begin
        e0 <= push_data;
      end else begin
        e1 <= push_data;
      end
    end else if (pop) begin
      e0 <= e1;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/window_first_negative_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// window_first_negative_core
// Oldest negative sample in a sliding window over a signed sample stream.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the result buffer is not full; the
// queue RAM is read and written at most once per cycle, with the next front
// entry prefetched. Results are registered in the output buffer on accept.
// Reset: synchronous; clears queue pointers, position, sample count and the
// result buffer, and sets window_size to 3. Queue RAM contents are not
// cleared, so items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module window_first_negative_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Sample channel
  input  wire logic                              sample_valid,
  output logic                                   sample_stall,
  input  wire logic signed [wfn_pkg::DATA_W-1:0] sample,
  input  wire logic                              last_sample,
  // Result channel
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic signed [wfn_pkg::DATA_W-1:0]      first_negative,
  output logic                                   found,
  // Configuration channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wfn_pkg::CFG_W-1:0]         cfg_data
);

  logic [wfn_pkg::CFG_W-1:0] window_size;
  logic                      accept;
  logic                      has_result;
  logic                      buf_full;
  wfn_pkg::result_t          result, out_data;

  assign cfg_ready    = 1'b1;
  assign sample_stall = buf_full;
  assign accept       = sample_valid && !buf_full;

  // Window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= wfn_pkg::WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_size <= cfg_data;
    end
  end

  wfn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (sample),
    .last_sample(last_sample),
    .window_size(window_size),
    .has_result (has_result),
    .result     (result)
  );

  wfn_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && has_result),
    .push_data(result),
    .full     (buf_full),
    .out_valid(result_valid),
    .out_stall(result_stall),
    .out_data (out_data)
  );

  assign first_negative = out_data.first_negative;
  assign found          = out_data.found;

endmodule
`default_nettype wire

/* tb/sv/window_first_negative_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_first_negative_checker
// Watches the sample, result and configuration channels of the core. It keeps
// its own copy of the negative-sample ring and sequence counters, predicts one
// window result per accepted sample once the window is full, and compares
// every accepted result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module window_first_negative_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              sample_valid,
  input  wire logic                              sample_stall,
  input  wire logic signed [wfn_pkg::DATA_W-1:0] sample,
  input  wire logic                              last_sample,
  input  wire logic                              result_valid,
  input  wire logic                              result_stall,
  input  wire logic signed [wfn_pkg::DATA_W-1:0] first_negative,
  input  wire logic                              found,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [wfn_pkg::CFG_W-1:0]         cfg_data,
  output int                                     fail_count,
  output int                                     outstanding
);

  localparam int RING_DEPTH = wfn_pkg::MAX_WINDOW;

  // Predictor state
  logic [wfn_pkg::CFG_W-1:0] window_reg;
  wfn_pkg::entry_t           neg_ring [RING_DEPTH];
  int                        ring_head;
  int                        ring_tail;
  int                        ring_fill;
  logic [wfn_pkg::POS_W-1:0] sample_pos;
  int                        seq_seen;

  // Window results still owed by the core
  wfn_pkg::result_t          expected_windows [$];
  int                        mismatches = 0;

  assign fail_count = mismatches;

  initial outstanding = 0;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic clear_sequence();
    ring_head  = 0;
    ring_tail  = 0;
    ring_fill  = 0;
    sample_pos = '0;
    seq_seen   = 0;
  endtask

  // One sample through the window: retire, queue, then report once full
  task automatic advance_window(input logic signed [wfn_pkg::DATA_W-1:0] s,
                                input logic closes);
    int                        k;
    logic [wfn_pkg::POS_W-1:0] retire_pos;
    wfn_pkg::result_t          r;
    if (window_reg == '0) begin
      k = 1;
    end else if (int'(window_reg) > RING_DEPTH) begin
      k = RING_DEPTH;
    end else begin
      k = int'(window_reg);
    end
    retire_pos = sample_pos - wfn_pkg::POS_W'(k);
    if (ring_fill > 0 && neg_ring[ring_head].pos == retire_pos) begin
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_fill--;
    end
    // full ring drops the new negative
    if (s[wfn_pkg::DATA_W-1] && ring_fill < RING_DEPTH) begin
      neg_ring[ring_tail].value = s;
      neg_ring[ring_tail].pos   = sample_pos;
      ring_tail = (ring_tail + 1) % RING_DEPTH;
      ring_fill++;
    end
    if (seq_seen < RING_DEPTH) begin
      seq_seen++;
    end
    if (seq_seen >= k) begin
      r.found          = (ring_fill > 0);
      r.first_negative = r.found ? neg_ring[ring_head].value : '0;
      expected_windows.push_back(r);
    end
    sample_pos = sample_pos + 1'b1;
    if (closes) begin
      clear_sequence();
    end
  endtask

  // Channel monitor: config, then result compare, then prediction
  always @(posedge clk) begin
    wfn_pkg::result_t want;
    if (rst) begin
      window_reg = wfn_pkg::WINDOW_RESET;
      clear_sequence();
      expected_windows.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_reg = cfg_data;
      end
      if (result_valid && !result_stall) begin
        if (expected_windows.size() == 0) begin
          flag_mismatch($sformatf("result %0d/%0b with no window pending",
                                  first_negative, found));
        end else begin
          want = expected_windows.pop_front();
          if (found !== want.found) begin
            flag_mismatch($sformatf("found %b, want %b", found, want.found));
          end
          if (first_negative !== want.first_negative) begin
            flag_mismatch($sformatf("first_negative %0d, want %0d",
                                    first_negative, want.first_negative));
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        advance_window(sample, last_sample);
      end
    end
    outstanding <= expected_windows.size();
  end

endmodule

/* tb/sv/window_first_negative_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_first_negative_core_tb
// Drives sample sequences and window-size writes into the core with random
// gaps on the sample side and random stalls on the result side. Checking is
// done by the checker instance; this top only makes stimulus and reports.
// ----------------------------------------------------------------------------
module window_first_negative_core_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1950;

  logic                              clk;
  logic                              rst;
  logic                              sample_valid;
  logic                              sample_stall;
  logic signed [wfn_pkg::DATA_W-1:0] sample;
  logic                              last_sample;
  logic                              result_valid;
  logic                              result_stall;
  logic signed [wfn_pkg::DATA_W-1:0] first_negative;
  logic                              found;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [wfn_pkg::CFG_W-1:0]         cfg_data;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent  = 0;
  bit calm        = 1'b0;

  window_first_negative_core dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .last_sample    (last_sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .first_negative (first_negative),
    .found          (found),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  window_first_negative_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .last_sample    (last_sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .first_negative (first_negative),
    .found          (found),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // Clock
  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure, off during calm stretches
  always @(posedge clk) begin
    result_stall <= !calm && ($urandom_range(99) < 7);
  end

  // Hand one sample over, with an optional random gap first
  task automatic send_sample(input logic signed [wfn_pkg::DATA_W-1:0] v,
                             input logic closes);
    while (!calm && $urandom_range(99) < 7) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= v;
    last_sample  <= closes;
    do @(posedge clk); while (sample_stall);
    items_sent++;
  endtask

  // Hold off the sample side until every owed window result is back
  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Window size write, only with the core idle
  task automatic write_window(input int w);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= wfn_pkg::CFG_W'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [wfn_pkg::DATA_W-1:0] pick_sample(input int neg_pct);
    logic signed [wfn_pkg::DATA_W-1:0] v;
    int r;
    r = $urandom_range(99);
    if (r < 3) begin
      v = 32'sh8000_0000;
    end else if (r < 5) begin
      v = 32'sh7FFF_FFFF;
    end else if (r < 7) begin
      v = -32'sd1;
    end else if (r < 9) begin
      v = '0;
    end else begin
      v = $urandom;
      v[wfn_pkg::DATA_W-1] = ($urandom_range(99) < neg_pct);
    end
    return v;
  endfunction

  // One run of samples; closes the sequence on the final item if asked
  task automatic run_sequence(input int len, input int neg_pct, input bit closes);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(299) == 0) begin
        drain_results();
      end
      send_sample(pick_sample(neg_pct), closes && (i == len - 1));
    end
  endtask

  initial begin : stimulus
    int r;
    int w;
    int k;
    int nseq;
    int len;
    int base;
    bit closes;

    clk          = 1'b0;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    last_sample  = 1'b0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset window of 3 with field extremes
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd5, 1'b1);
    // short sequence gives nothing
    send_sample(-32'sd9, 1'b0);
    send_sample(-32'sd10, 1'b1);
    // window of one
    write_window(1);
    send_sample(-32'sd7, 1'b0);
    send_sample(32'sd3, 1'b1);
    // zero acts as one
    write_window(0);
    send_sample(-32'sd2, 1'b1);
    // oversize acts as the maximum; short sequence
    write_window(511);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd4, 1'b1);
    // size changed in the middle of a sequence
    write_window(4);
    send_sample(32'sd1, 1'b0);
    send_sample(-32'sd5, 1'b0);
    send_sample(32'sd2, 1'b0);
    write_window(2);
    send_sample(-32'sd6, 1'b0);
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd8, 1'b1);

    base = items_sent;

    // Full ring: largest window of negatives, then shrink it so nothing retires
    write_window(256);
    run_sequence(264, 100, 1'b0);
    write_window(3);
    run_sequence(6, 100, 1'b1);

    // Random phases of window size and sequences
    while (items_sent - base < RANDOM_ITEMS) begin
      calm = (items_sent - base >= 500) && (items_sent - base < 900);
      r = $urandom_range(99);
      if (r < 50) begin
        w = $urandom_range(1, 8);
      end else if (r < 78) begin
        w = $urandom_range(9, 40);
      end else if (r < 88) begin
        w = $urandom_range(41, 120);
      end else if (r < 93) begin
        w = $urandom_range(200, 256);
      end else if (r < 96) begin
        w = 0;
      end else begin
        w = $urandom_range(257, 511);
      end
      write_window(w);
      k = (w == 0) ? 1 : ((w > wfn_pkg::MAX_WINDOW) ? wfn_pkg::MAX_WINDOW : w);
      nseq = (k >= 64) ? 1 : $urandom_range(1, 4);
      for (int s = 0; s < nseq; s++) begin
        if ($urandom_range(99) < 15) begin
          len = $urandom_range(1, k);
        end else if (k >= 64) begin
          len = k + $urandom_range(0, 16);
        end else begin
          len = k + $urandom_range(0, 2 * k + 4);
        end
        // an open sequence carries over into the next window size
        closes = (s < nseq - 1) || ($urandom_range(99) < 75);
        run_sequence(len, $urandom_range(0, 100), closes);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
